// File: hdl/i2cmbe_pkg.sv
package i2cmbe_pkg;

  // Default width of the half-period / hold timer.
  localparam int TIMER_WIDTH_DEF = 16;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Register reset values
  localparam logic [15:0] HALF_PERIOD_RST = 16'd100;
  localparam logic [4:0]  ACK_POLL_RST    = 5'd20;
  localparam logic [15:0] SHORT_HOLD_RST  = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_PERIOD = 2'd0,
    REG_ACK_POLL    = 2'd1,
    REG_SHORT_HOLD  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_A    = 4'd1,
    PH_B    = 4'd2,
    PH_C    = 4'd3,
    PH_D    = 4'd4,
    PH_E    = 4'd5,
    PH_F    = 4'd6,
    PH_G    = 4'd7,
    PH_H    = 4'd8
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
  } res_item_t;

  typedef struct packed {
    logic [15:0] half_period_cycles;
    logic [4:0]  ack_poll_limit;
    logic [15:0] short_hold_cycles;
  } cfg_t;

endpackage

// File: hdl/i2cmbe_cfg.sv
module i2cmbe_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]  cfg_data,
  output i2cmbe_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_cycles <= i2cmbe_pkg::HALF_PERIOD_RST;
      cfg.ack_poll_limit     <= i2cmbe_pkg::ACK_POLL_RST;
      cfg.short_hold_cycles  <= i2cmbe_pkg::SHORT_HOLD_RST;
    end else if (cfg_we) begin
      case (i2cmbe_pkg::cfg_reg_t'(cfg_index))
        i2cmbe_pkg::REG_HALF_PERIOD: cfg.half_period_cycles <= cfg_data[15:0];
        i2cmbe_pkg::REG_ACK_POLL:    cfg.ack_poll_limit     <= cfg_data[4:0];
        i2cmbe_pkg::REG_SHORT_HOLD:  cfg.short_hold_cycles  <= cfg_data[15:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

// File: hdl/i2cmbe_in_reg.sv
module i2cmbe_in_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  i2cmbe_pkg::cmd_item_t  in_data,
  input  logic                   advance,
  output logic                   item_valid,
  output i2cmbe_pkg::cmd_item_t  item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

// File: hdl/i2cmbe_engine.sv
module i2cmbe_engine #(
  parameter int TIMER_WIDTH = i2cmbe_pkg::TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  i2cmbe_pkg::cmd_item_t  item,
  input  i2cmbe_pkg::cfg_t       cfg,
  output i2cmbe_pkg::res_item_t  res
);

  i2cmbe_pkg::phase_t      phase, phase_next;
  i2cmbe_pkg::op_t         current_op, current_op_next;
  logic [3:0]              bit_index, bit_index_next;
  logic [TIMER_WIDTH-1:0]  wait_counter, wait_counter_next;
  logic [4:0]              poll_counter, poll_counter_next;
  logic [7:0]              shift_byte, shift_byte_next;
  logic                    ack_to_send, ack_to_send_next;
  logic                    scl_level, scl_level_next;
  logic                    sda_level, sda_level_next;
  logic                    ack_result, ack_result_next;
  logic                    done;
  logic                    do_enter;
  i2cmbe_pkg::phase_t      target;
  logic [15:0]             wait_sel;

  // Mask a wait to the timer width; zero means one tick.
  function automatic logic [TIMER_WIDTH-1:0] load_wait(input logic [15:0] w);
    logic [31:0] wide;
    wide = {16'b0, w};
    if (wide[TIMER_WIDTH-1:0] == '0) begin
      load_wait = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      load_wait = wide[TIMER_WIDTH-1:0];
    end
  endfunction

  // Next state: first the step itself, then the entry actions of the new phase.
  always_comb begin
    phase_next        = phase;
    current_op_next   = current_op;
    bit_index_next    = bit_index;
    wait_counter_next = wait_counter;
    poll_counter_next = poll_counter;
    shift_byte_next   = shift_byte;
    ack_to_send_next  = ack_to_send;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    ack_result_next   = ack_result;
    done              = 1'b0;
    do_enter          = 1'b0;
    target            = i2cmbe_pkg::PH_IDLE;
    wait_sel          = cfg.half_period_cycles;

    if (phase == i2cmbe_pkg::PH_IDLE) begin
      if (item.cmd_valid) begin
        current_op_next   = i2cmbe_pkg::op_t'(item.opcode);
        bit_index_next    = 4'd0;
        poll_counter_next = 5'd0;
        ack_to_send_next  = item.send_ack;
        if (i2cmbe_pkg::op_t'(item.opcode) == i2cmbe_pkg::OP_WRITE) begin
          shift_byte_next = item.tx_byte;
        end
        do_enter = 1'b1;
        target   = i2cmbe_pkg::PH_A;
      end
    end else if (wait_counter > {{(TIMER_WIDTH-1){1'b0}}, 1'b1}) begin
      wait_counter_next = wait_counter - {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      case (phase)
        i2cmbe_pkg::PH_A: begin
          do_enter = 1'b1;
          target   = i2cmbe_pkg::PH_B;
        end
        i2cmbe_pkg::PH_B: begin
          if (current_op == i2cmbe_pkg::OP_READ) begin
            shift_byte_next = {shift_byte[6:0], item.sda_in};
          end
          do_enter = 1'b1;
          target   = i2cmbe_pkg::PH_C;
        end
        i2cmbe_pkg::PH_C: begin
          if (current_op inside {i2cmbe_pkg::OP_START, i2cmbe_pkg::OP_STOP}) begin
            phase_next = i2cmbe_pkg::PH_IDLE;
            done       = 1'b1;
          end else begin
            if (current_op == i2cmbe_pkg::OP_WRITE) begin
              shift_byte_next = {shift_byte[6:0], 1'b0};
            end
            bit_index_next = bit_index + 4'd1;
            do_enter       = 1'b1;
            target         = (bit_index_next >= 4'd8) ? i2cmbe_pkg::PH_D : i2cmbe_pkg::PH_A;
          end
        end
        i2cmbe_pkg::PH_D: begin
          do_enter = 1'b1;
          target   = i2cmbe_pkg::PH_E;
        end
        i2cmbe_pkg::PH_E: begin
          do_enter = 1'b1;
          if (current_op != i2cmbe_pkg::OP_WRITE) begin
            target = i2cmbe_pkg::PH_G;
          end else if (!item.sda_in) begin
            ack_result_next = 1'b1;
            target          = i2cmbe_pkg::PH_G;
          end else begin
            poll_counter_next = 5'd0;
            target            = i2cmbe_pkg::PH_F;
          end
        end
        i2cmbe_pkg::PH_F: begin
          do_enter = 1'b1;
          if (poll_counter >= cfg.ack_poll_limit) begin
            ack_result_next = 1'b0;
            target          = i2cmbe_pkg::PH_G;
          end else begin
            poll_counter_next = poll_counter + 5'd1;
            if (!item.sda_in) begin
              ack_result_next = 1'b1;
              target          = i2cmbe_pkg::PH_G;
            end else begin
              target = i2cmbe_pkg::PH_F;
            end
          end
        end
        i2cmbe_pkg::PH_G: begin
          do_enter = 1'b1;
          target   = i2cmbe_pkg::PH_H;
        end
        i2cmbe_pkg::PH_H: begin
          phase_next = i2cmbe_pkg::PH_IDLE;
          done       = 1'b1;
        end
        default: begin
          phase_next = i2cmbe_pkg::PH_IDLE;
        end
      endcase
    end

    if (do_enter) begin
      phase_next = target;
      case (target)
        i2cmbe_pkg::PH_A: begin
          case (current_op_next)
            i2cmbe_pkg::OP_START: begin
              sda_level_next = 1'b1;
              scl_level_next = 1'b1;
            end
            i2cmbe_pkg::OP_STOP:  sda_level_next = 1'b0;
            i2cmbe_pkg::OP_WRITE: sda_level_next = shift_byte_next[7];
            default:              sda_level_next = 1'b1;
          endcase
        end
        i2cmbe_pkg::PH_B: begin
          if (current_op_next == i2cmbe_pkg::OP_START) sda_level_next = 1'b0;
          else scl_level_next = 1'b1;
        end
        i2cmbe_pkg::PH_C: begin
          if (current_op_next == i2cmbe_pkg::OP_STOP) sda_level_next = 1'b1;
          else scl_level_next = 1'b0;
        end
        i2cmbe_pkg::PH_D: begin
          if (current_op_next == i2cmbe_pkg::OP_READ) sda_level_next = !ack_to_send_next;
        end
        i2cmbe_pkg::PH_E: begin
          scl_level_next = 1'b1;
          if (current_op_next == i2cmbe_pkg::OP_WRITE) sda_level_next = 1'b1;
        end
        i2cmbe_pkg::PH_F: begin
          wait_sel = {2'b00, cfg.half_period_cycles[15:2]};  // quarter period
        end
        i2cmbe_pkg::PH_G: begin
          scl_level_next = 1'b0;
          wait_sel       = cfg.short_hold_cycles;
        end
        i2cmbe_pkg::PH_H: begin
          sda_level_next = 1'b1;
        end
        default: ;
      endcase
      wait_counter_next = load_wait(wait_sel);
    end
  end

  // Result of this step
  always_comb begin
    res.scl_release = scl_level_next;
    res.sda_release = sda_level_next;
    res.busy_res    = (phase_next != i2cmbe_pkg::PH_IDLE) || done;
    res.done_res    = done;
    res.rx_byte     = shift_byte_next;
    res.ack_ok      = ack_result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= i2cmbe_pkg::PH_IDLE;
      current_op   <= i2cmbe_pkg::OP_START;
      bit_index    <= 4'd0;
      wait_counter <= '0;
      poll_counter <= 5'd0;
      shift_byte   <= 8'd0;
      ack_to_send  <= 1'b0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
      ack_result   <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      current_op   <= current_op_next;
      bit_index    <= bit_index_next;
      wait_counter <= wait_counter_next;
      poll_counter <= poll_counter_next;
      shift_byte   <= shift_byte_next;
      ack_to_send  <= ack_to_send_next;
      scl_level    <= scl_level_next;
      sda_level    <= sda_level_next;
      ack_result   <= ack_result_next;
    end
  end

endmodule

// File: hdl/i2c_master_byte_engine.sv
// I2C master byte engine. Each input transaction is one clock tick of the
// bus engine: it may carry a command (start, stop, write byte, read byte;
// honored only while the engine is idle) and always carries the sampled SDA
// level. Each input transaction yields exactly one output transaction with
// the open-drain SCL/SDA release levels, busy/done flags, the shift register
// (rx_byte) and the last write's acknowledge result. The engine takes one
// transaction per clock while the output is not stalled; an accepted input
// passes the input register, then the step logic and the result register.
// Both stages advance together whenever the result register is empty or
// being taken, so stalls on the output only hold the pipeline. Bus timing is
// counted in transactions: half_period_cycles per SCL half period, a quarter
// of it between acknowledge polls, short_hold_cycles after the acknowledge
// clock falls. Configuration writes land on the next clock and should only
// be issued while no command is running.
module i2c_master_byte_engine #(
  parameter int TIMER_WIDTH = i2cmbe_pkg::TIMER_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]  cfg_data,
  // tick / command channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  i2cmbe_pkg::cmd_item_t              in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output i2cmbe_pkg::res_item_t              out_data
);

  i2cmbe_pkg::cfg_t       cfg;
  i2cmbe_pkg::cmd_item_t  item;
  i2cmbe_pkg::res_item_t  res;
  logic                   item_valid;
  logic                   advance;

  // One step per transaction moved from the input register to the result
  // register; the result register frees up when empty or being taken.
  assign advance = item_valid && (!out_valid || out_ready);

  i2cmbe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cmbe_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cmbe_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

// File: hdl/i2cmbe_checker.sv
module i2cmbe_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input i2cmbe_pkg::res_item_t  out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // done only on a busy tick
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> out_data.busy_res)
    else $error("done without busy");

  // input side never blocks unless the output is stalled
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !out_ready) |-> in_ready)
    else $error("input stalled with free result register");

  // a command completes on one tick only
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.done_res |=> !(out_valid && out_data.done_res))
    else $error("done on consecutive results");

endmodule

bind i2c_master_byte_engine i2cmbe_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: sim/i2c_bus_checker.sv
`timescale 1ns / 100ps

module i2c_bus_checker import i2cmbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  cmd_item_t             in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  res_item_t             out_data,
  output int                    mismatch_count,
  output int                    pending_count
);

  // register shadow
  logic [15:0] half_period;
  logic [4:0]  poll_limit;
  logic [15:0] hold_len;

  // bus engine shadow
  phase_t      ph;
  op_t         cur_op;
  logic [3:0]  bit_cnt;
  logic [15:0] wait_cnt;
  logic [4:0]  poll_cnt;
  logic [7:0]  shreg;
  logic        ack_tx;
  logic        scl_lvl;
  logic        sda_lvl;
  logic        ack_seen;

  res_item_t   line_levels_q[$];
  res_item_t   predicted;
  res_item_t   oldest;

  // move to a step, set the lines it drives and load its wait
  function automatic void enter_step(phase_t p);
    logic [15:0] w;
    w  = half_period;
    ph = p;
    case (p)
      PH_A: begin
        case (cur_op)
          OP_START: begin
            sda_lvl = 1'b1;
            scl_lvl = 1'b1;
          end
          OP_STOP:  sda_lvl = 1'b0;
          OP_WRITE: sda_lvl = shreg[7];
          default:  sda_lvl = 1'b1;
        endcase
      end
      PH_B: if (cur_op == OP_START) sda_lvl = 1'b0; else scl_lvl = 1'b1;
      PH_C: if (cur_op == OP_STOP) sda_lvl = 1'b1; else scl_lvl = 1'b0;
      PH_D: if (cur_op == OP_READ) sda_lvl = ~ack_tx;
      PH_E: begin
        scl_lvl = 1'b1;
        if (cur_op == OP_WRITE) sda_lvl = 1'b1;
      end
      PH_F: w = half_period >> 2;
      PH_G: begin
        scl_lvl = 1'b0;
        w = hold_len;
      end
      PH_H: sda_lvl = 1'b1;
      default: ;
    endcase
    wait_cnt = (w == 16'd0) ? 16'd1 : w;
  endfunction

  // one bus tick: returns the line levels and flags after it
  function automatic res_item_t advance_bus(cmd_item_t c);
    res_item_t r;
    logic      fin;
    fin = 1'b0;
    if (ph == PH_IDLE) begin
      if (c.cmd_valid) begin
        cur_op   = op_t'(c.opcode);
        bit_cnt  = 4'd0;
        poll_cnt = 5'd0;
        ack_tx   = c.send_ack;
        if (cur_op == OP_WRITE) shreg = c.tx_byte;
        enter_step(PH_A);
      end
    end else if (wait_cnt > 16'd1) begin
      wait_cnt = wait_cnt - 16'd1;
    end else begin
      case (ph)
        PH_A: enter_step(PH_B);
        PH_B: begin
          if (cur_op == OP_READ) shreg = {shreg[6:0], c.sda_in};
          enter_step(PH_C);
        end
        PH_C: begin
          if (cur_op == OP_START || cur_op == OP_STOP) begin
            ph  = PH_IDLE;
            fin = 1'b1;
          end else begin
            if (cur_op == OP_WRITE) shreg = {shreg[6:0], 1'b0};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) enter_step(PH_D);
            else enter_step(PH_A);
          end
        end
        PH_D: enter_step(PH_E);
        PH_E: begin
          if (cur_op != OP_WRITE) begin
            enter_step(PH_G);
          end else if (!c.sda_in) begin
            ack_seen = 1'b1;
            enter_step(PH_G);
          end else begin
            poll_cnt = 5'd0;
            enter_step(PH_F);
          end
        end
        PH_F: begin
          if (poll_cnt >= poll_limit) begin
            ack_seen = 1'b0;
            enter_step(PH_G);
          end else begin
            poll_cnt = poll_cnt + 5'd1;
            if (!c.sda_in) begin
              ack_seen = 1'b1;
              enter_step(PH_G);
            end else begin
              enter_step(PH_F);
            end
          end
        end
        PH_G: enter_step(PH_H);
        PH_H: begin
          ph  = PH_IDLE;
          fin = 1'b1;
        end
        default: ph = PH_IDLE;
      endcase
    end
    r.scl_release = scl_lvl;
    r.sda_release = sda_lvl;
    r.busy_res    = (ph != PH_IDLE) || fin;
    r.done_res    = fin;
    r.rx_byte     = shreg;
    r.ack_ok      = ack_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      half_period    = HALF_PERIOD_RST;
      poll_limit     = ACK_POLL_RST;
      hold_len       = SHORT_HOLD_RST;
      ph             = PH_IDLE;
      cur_op         = OP_START;
      bit_cnt        = 4'd0;
      wait_cnt       = 16'd0;
      poll_cnt       = 5'd0;
      shreg          = 8'd0;
      ack_tx         = 1'b0;
      scl_lvl        = 1'b1;
      sda_lvl        = 1'b1;
      ack_seen       = 1'b0;
      line_levels_q.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = advance_bus(in_data);
        line_levels_q.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (line_levels_q.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("%0t: result with nothing pending: %p", $realtime, out_data);
        end else begin
          oldest = line_levels_q.pop_front();
          if (out_data.scl_release !== oldest.scl_release ||
              out_data.sda_release !== oldest.sda_release ||
              out_data.busy_res    !== oldest.busy_res    ||
              out_data.done_res    !== oldest.done_res    ||
              out_data.rx_byte     !== oldest.rx_byte     ||
              out_data.ack_ok      !== oldest.ack_ok) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display("%0t: mismatch exp %p got %p", $realtime, oldest, out_data);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_PERIOD: half_period = cfg_data;
          REG_ACK_POLL:    poll_limit  = cfg_data[4:0];
          REG_SHORT_HOLD:  hold_len    = cfg_data;
          default: ;
        endcase
      end
    end
    pending_count = line_levels_q.size();
  end

endmodule

// File: sim/tb_i2c_master_byte_engine.sv
`timescale 1ns / 100ps

module tb_i2c_master_byte_engine;
  import i2cmbe_pkg::*;

  // how the SDA line answers on ticks the testbench sends
  typedef enum int {SDA_RANDOM, SDA_LOW, SDA_HIGH, SDA_MOSTLY_HIGH} sda_mode_t;

  localparam int N_ITEMS   = 1250;  // input transactions in the whole run, roughly
  localparam int LONG_HOLD = 300;   // cycles of the one long receiver stall
  localparam int CALM_TAIL = 200;   // input transactions at the end with no idling

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  cmd_item_t             in_data;
  logic                  out_valid;
  logic                  out_ready;
  res_item_t             out_data;

  int mismatch_count;
  int pending_count;

  // sender side bookkeeping (blocking, owned by the stimulus process)
  int n_sent       = 0;
  int last_cmd_idx = -1;
  // result side bookkeeping (owned by the result monitor below)
  int n_recv       = 0;
  int idle_seen_idx = -1;

  sda_mode_t sda_mode    = SDA_RANDOM;
  int        tx_gap_pct  = 0;
  int        rx_gap_pct  = 0;
  bit        long_hold_req  = 1'b0;
  bit        long_hold_done = 1'b0;

  int next_reconfig;

  i2c_master_byte_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  i2c_bus_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Result monitor: each result transaction k belongs to input transaction k.
  // A result with busy low tells the engine was idle on that tick.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (!out_data.busy_res) idle_seen_idx <= n_recv;
      n_recv <= n_recv + 1;
    end
  end

  // Receiver: random hold-off bursts, plus one long stall on request so the
  // pipeline fills and the input side backs up.
  initial begin
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < rx_gap_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Build one bus tick; SDA follows the current answer mode.
  function automatic cmd_item_t bus_tick(logic cv, op_t op, logic [7:0] b, logic ack);
    cmd_item_t t;
    t.cmd_valid = cv;
    t.opcode    = op;
    t.tx_byte   = b;
    t.send_ack  = ack;
    case (sda_mode)
      SDA_LOW:         t.sda_in = 1'b0;
      SDA_HIGH:        t.sda_in = 1'b1;
      SDA_MOSTLY_HIGH: t.sda_in = ($urandom_range(0, 7) != 0);
      default:         t.sda_in = 1'($urandom_range(0, 1));
    endcase
    return t;
  endfunction

  function automatic int pick_gap_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 15;
      default: return 30;
    endcase
  endfunction

  // Offer one tick transaction (with an optional gap first) and wait for it
  // to be taken. Called and returned at a rising edge. in_ready is sampled
  // at the falling edge, where it is settled for the next rising edge.
  task automatic send_tick(input cmd_item_t item);
    bit rdy;
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    forever begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
      if (rdy) break;
    end
    if (item.cmd_valid) last_cmd_idx = n_sent;
    n_sent = n_sent + 1;
  endtask

  // Keep ticking with no command until a result after the last command
  // shows the engine idle. Junk in the unused fields is harmless.
  task automatic settle_idle();
    while (idle_seen_idx <= last_cmd_idx)
      send_tick(bus_tick(1'b0, op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1))));
  endtask

  // Engine is idle on entry; issue one command and run it to completion.
  task automatic run_cmd(input op_t op, input logic [7:0] b, input logic ack,
                         input sda_mode_t mode);
    sda_mode = mode;
    send_tick(bus_tick(1'b1, op, b, ack));
    settle_idle();
  endtask

  // Engine idle, input stopped, every result in, then a margin.
  task automatic quiesce();
    settle_idle();
    in_valid <= 1'b0;
    while (n_recv != n_sent) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // One register, only while nothing is in flight.
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // All three registers, one per cycle, only while nothing is in flight.
  task automatic reconfigure(input logic [15:0] hp, input logic [4:0] polls,
                             input logic [15:0] hold);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_PERIOD;
    cfg_data  <= hp;
    @(posedge clk);
    cfg_index <= REG_ACK_POLL;
    cfg_data  <= 16'(polls);
    @(posedge clk);
    cfg_index <= REG_SHORT_HOLD;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_HALF_PERIOD;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    tx_gap_pct = 10;
    rx_gap_pct = 10;

    // reset poll limit and hold on a short half period; no acknowledge, so
    // every poll runs out
    write_reg(REG_HALF_PERIOD, 16'd4);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_HIGH);

    // short timing, no retries: acknowledged write, ACK read
    reconfigure(16'd4, 5'd0, 16'd1);
    run_cmd(OP_START, 8'h00, 1'b1, SDA_RANDOM);
    run_cmd(OP_WRITE, 8'h3C, 1'b1, SDA_LOW);
    run_cmd(OP_READ,  8'h00, 1'b1, SDA_RANDOM);
    run_cmd(OP_STOP,  8'h00, 1'b0, SDA_RANDOM);
    // stop with no start before it, then a repeated start
    run_cmd(OP_STOP,  8'h00, 1'b0, SDA_RANDOM);
    run_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM);
    run_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM);

    // waits that compute to zero: quarter of a tiny half period, zero hold;
    // acknowledge arrives after some polls, then a NACK read
    reconfigure(16'd3, 5'd31, 16'd0);
    run_cmd(OP_WRITE, 8'h81, 1'b0, SDA_MOSTLY_HIGH);
    run_cmd(OP_READ,  8'h00, 1'b0, SDA_RANDOM);

    // ---- random part ----
    // Single commands with random content and ACK behavior, and blocks of
    // raw noise where commands land at any moment, including while busy and
    // on the done tick.
    next_reconfig = n_sent;
    while (n_sent < N_ITEMS) begin
      if (n_sent >= next_reconfig) begin
        tx_gap_pct = pick_gap_pct();
        rx_gap_pct = pick_gap_pct();
        reconfigure(($urandom_range(0, 5) == 0) ? 16'd3 : 16'($urandom_range(4, 6)),
                    ($urandom_range(0, 3) == 0) ? 5'($urandom_range(8, 31))
                                                : 5'($urandom_range(0, 7)),
                    16'($urandom_range(0, 6)));
        next_reconfig = n_sent + $urandom_range(150, 300);
      end
      if (N_ITEMS - n_sent < CALM_TAIL) begin
        tx_gap_pct = 0;
        rx_gap_pct = 0;
      end
      // receiver takes the long stall once, while ticks keep coming
      long_hold_req = 1'b1;

      if ($urandom_range(0, 3) == 0) begin
        sda_mode = SDA_RANDOM;
        repeat ($urandom_range(20, 80))
          send_tick(bus_tick($urandom_range(0, 2) == 0, op_t'($urandom_range(0, 3)),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
        settle_idle();
      end else begin
        run_cmd(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), sda_mode_t'($urandom_range(0, 3)));
      end
    end

    // drain and give the verdict
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    quiesce();
    if (mismatch_count == 0 && pending_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
